[src/hstr_pkg.sv]
// hstr_pkg: shared types and constants for the hatch servo toggle and ramp controller
// no dependencies

package hstr_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_PWM    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_PWM     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_WINDOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_HOLD   = 3'd4;

    localparam logic [7:0]  RST_CLOSE_PWM    = 8'd53;
    localparam logic [7:0]  RST_OPEN_PWM     = 8'd75;
    localparam logic [7:0]  RST_RAMP_STEP    = 8'd100;
    localparam logic [15:0] RST_PRESS_WINDOW = 16'd500;
    localparam logic [15:0] RST_CLOSE_HOLD   = 16'd800;

    localparam logic [1:0] STEP_IDLE   = 2'd0;
    localparam logic [1:0] STEP_ARMED  = 2'd1;
    localparam logic [1:0] STEP_FIRE   = 2'd2;
    localparam logic [1:0] STEP_UNUSED = 2'd3;

    localparam logic [1:0] PRESS_OPEN = 2'd2;
    localparam logic [1:0] PRESS_MAX  = 2'd3;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;

    typedef struct packed {
        logic [7:0]  close_pwm;
        logic [7:0]  open_pwm;
        logic [7:0]  ramp_step;
        logic [15:0] press_window;
        logic [15:0] close_hold;
    } t_cfg;

    typedef struct packed {
        logic        starting;
        logic        sw2_middle;
        logic        sw1_up;
        logic        key_mode;
        logic        key_r;
        logic        key_s;
        logic        close_keys;
        logic        buff_hit;
        logic        shots_nonzero;
        logic [31:0] now_tick;
    } t_in;

    typedef struct packed {
        logic [7:0]  target_pwm;
        logic [7:0]  actual_pwm;
        logic [1:0]  remote_step;
        logic        key_open;
        logic        r_released;
        logic [1:0]  press_count;
        logic [31:0] last_r_press;
        logic [31:0] s_hold_start;
        logic        came_from_remote;
    } t_state;

    typedef struct packed {
        logic [7:0] servo_pwm;
        logic       is_open;
        logic       is_opening;
        logic       clear_shots;
    } t_result;

endpackage

[src/hstr_step.sv]
// hstr_step: next-state and result logic for one control tick
// depends on hstr_pkg

module hstr_step (
    input  hstr_pkg::t_cfg    i_cfg,
    input  hstr_pkg::t_state  i_cur,
    input  hstr_pkg::t_in     i_word,
    output hstr_pkg::t_state  o_nxt,
    output hstr_pkg::t_result o_res
);
    import hstr_pkg::*;

    t_state     s;
    logic       clr;
    logic       toggle;
    logic [8:0] up_sum;
    logic [7:0] down_diff;
    logic [31:0] r_age;
    logic [31:0] s_age;

    always_comb begin
        s         = i_cur;
        clr       = 1'b0;
        toggle    = 1'b0;
        r_age     = 32'd0;
        s_age     = 32'd0;
        up_sum    = 9'd0;
        down_diff = 8'd0;
        if (i_word.starting) begin
            s.target_pwm  = i_cfg.close_pwm;
            s.actual_pwm  = i_cfg.close_pwm;
            s.r_released  = 1'b1;
            s.press_count = 2'd0;
        end else begin
            // remote one-shot toggle
            if (i_word.sw2_middle) begin
                if (i_word.sw1_up) begin
                    if (s.remote_step == STEP_ARMED) begin
                        s.remote_step = STEP_FIRE;
                    end else if (s.remote_step == STEP_FIRE) begin
                        s.remote_step = STEP_IDLE;
                    end
                end else begin
                    s.remote_step = STEP_ARMED;
                end
            end else begin
                s.remote_step = STEP_IDLE;
            end
            toggle = (s.remote_step == STEP_FIRE);
            if (toggle) begin
                s.target_pwm = (s.target_pwm == i_cfg.open_pwm) ? i_cfg.close_pwm
                                                                : i_cfg.open_pwm;
            end

            if (i_word.key_mode) begin
                if (s.came_from_remote) begin
                    s.key_open         = 1'b0;
                    s.target_pwm       = i_cfg.close_pwm;
                    s.came_from_remote = 1'b0;
                end
                if (!s.key_open) begin
                    r_age = i_word.now_tick - s.last_r_press;
                    if (!i_word.key_r) begin
                        s.r_released = 1'b1;
                        if (r_age > {16'd0, i_cfg.press_window}) begin
                            s.press_count = 2'd0;
                        end
                    end
                    if (i_word.key_r && s.r_released && !i_word.buff_hit) begin
                        s.last_r_press = i_word.now_tick;
                        s.r_released   = 1'b0;
                        if (s.press_count != PRESS_MAX) begin
                            s.press_count = s.press_count + 2'd1;
                        end
                    end
                    if (s.press_count >= PRESS_OPEN) begin
                        s.key_open     = 1'b1;
                        s.target_pwm   = i_cfg.open_pwm;
                        clr            = i_word.shots_nonzero;
                        s.s_hold_start = i_word.now_tick;
                    end else begin
                        s.target_pwm = i_cfg.close_pwm;
                    end
                end else begin
                    if (!i_word.key_r) begin
                        s.r_released = 1'b1;
                    end
                    if (!i_word.key_s) begin
                        s.s_hold_start = i_word.now_tick;
                    end
                    s_age = i_word.now_tick - s.s_hold_start;
                    if ((s_age > {16'd0, i_cfg.close_hold}) || i_word.close_keys) begin
                        s.key_open = 1'b0;
                    end else begin
                        s.target_pwm = i_cfg.open_pwm;
                    end
                    s.press_count = 2'd0;
                end
            end else begin
                s.key_open         = 1'b0;
                s.r_released       = 1'b1;
                s.press_count      = 2'd0;
                s.came_from_remote = 1'b1;
            end
        end

        // ramp toward target, clamped
        up_sum    = {1'b0, s.actual_pwm} + {1'b0, i_cfg.ramp_step};
        down_diff = s.actual_pwm - s.target_pwm;
        if (s.actual_pwm < s.target_pwm) begin
            s.actual_pwm = (up_sum > {1'b0, s.target_pwm}) ? s.target_pwm : up_sum[7:0];
        end else if (s.actual_pwm > s.target_pwm) begin
            s.actual_pwm = (down_diff > i_cfg.ramp_step) ? s.actual_pwm - i_cfg.ramp_step
                                                         : s.target_pwm;
        end

        o_nxt             = s;
        o_res.servo_pwm   = s.actual_pwm;
        o_res.is_open     = (s.actual_pwm == i_cfg.open_pwm);
        o_res.is_opening  = (s.target_pwm == i_cfg.open_pwm);
        o_res.clear_shots = clr;
    end

endmodule

[src/hatch_servo_toggle_ramp_control_core.sv]
// hatch_servo_toggle_ramp_control_core: top level, stream ports, config registers, state
// depends on hstr_pkg and hstr_step

// One control tick enters per word; the block takes a new word in every cycle in which the
// output register is empty or being taken. The whole tick is worked out combinationally from
// the state registers and the incoming word; the result word appears in the output register
// in the cycle after acceptance and is held there until the downstream side takes it, while
// the next word is accepted in that same cycle. The state update loop sets the rate.

module hatch_servo_toggle_ramp_control_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // starting, sw2_middle, sw1_up, key_mode, key_r, key_s, close_keys, buff_hit,
    // shots_nonzero, now_tick[31:0], zero fill
    input  logic [hstr_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // servo_pwm[7:0], is_open, is_opening, clear_shots, zero fill
    output logic [hstr_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [hstr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hstr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import hstr_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;
    t_in     in_word;
    logic    in_accept;

    assign in_word.starting      = i_s_axis_tdata[0];
    assign in_word.sw2_middle    = i_s_axis_tdata[1];
    assign in_word.sw1_up        = i_s_axis_tdata[2];
    assign in_word.key_mode      = i_s_axis_tdata[3];
    assign in_word.key_r         = i_s_axis_tdata[4];
    assign in_word.key_s         = i_s_axis_tdata[5];
    assign in_word.close_keys    = i_s_axis_tdata[6];
    assign in_word.buff_hit      = i_s_axis_tdata[7];
    assign in_word.shots_nonzero = i_s_axis_tdata[8];
    assign in_word.now_tick      = i_s_axis_tdata[40:9];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    hstr_step u_step (
        .i_cfg  (r_cfg),
        .i_cur  (r_state),
        .i_word (in_word),
        .o_nxt  (n_state),
        .o_res  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.close_pwm    <= RST_CLOSE_PWM;
            r_cfg.open_pwm     <= RST_OPEN_PWM;
            r_cfg.ramp_step    <= RST_RAMP_STEP;
            r_cfg.press_window <= RST_PRESS_WINDOW;
            r_cfg.close_hold   <= RST_CLOSE_HOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CLOSE_PWM:    r_cfg.close_pwm    <= i_cfg_data[7:0];
                REG_OPEN_PWM:     r_cfg.open_pwm     <= i_cfg_data[7:0];
                REG_RAMP_STEP:    r_cfg.ramp_step    <= i_cfg_data[7:0];
                REG_PRESS_WINDOW: r_cfg.press_window <= i_cfg_data;
                REG_CLOSE_HOLD:   r_cfg.close_hold   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.target_pwm       <= RST_CLOSE_PWM;
            r_state.actual_pwm       <= RST_CLOSE_PWM;
            r_state.remote_step      <= STEP_IDLE;
            r_state.key_open         <= 1'b0;
            r_state.r_released       <= 1'b1;
            r_state.press_count      <= 2'd0;
            r_state.last_r_press     <= 32'd0;
            r_state.s_hold_start     <= 32'd0;
            r_state.came_from_remote <= 1'b1;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out.clear_shots, r_out.is_opening, r_out.is_open,
                              r_out.servo_pwm};

    // state moves only on an accepted word
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |=> $stable(r_state))
        else $error("state changed without an accepted word");

    // start-up leaves the servo parked at its target
    a_start_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && in_word.starting |=> r_state.actual_pwm == r_state.target_pwm)
        else $error("start-up did not park the servo");

    // press counter never reaches its saturation code
    a_press_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.press_count != PRESS_MAX)
        else $error("press count reached unreachable code");

    // remote step machine never reaches its unused code
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.remote_step != STEP_UNUSED)
        else $error("remote step reached unused code");

    // a shot-clear pulse comes only with the hatch heading open
    a_clear_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.clear_shots |-> r_out.is_opening)
        else $error("shot clear without opening target");

endmodule

[dv/testbench.sv]
// testbench: self-checking bench for hatch_servo_toggle_ramp_control_core
// drives control ticks over the stream ports, predicts each result word and compares it
// depends on hstr_pkg and the core rtl

module testbench;
    import hstr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_s_axis_tvalid;
    logic                    o_s_axis_tready;
    logic [IN_DATA_W-1:0]    i_s_axis_tdata;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready;
    logic [OUT_DATA_W-1:0]   o_m_axis_tdata;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    hatch_servo_toggle_ramp_control_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    // predictor copy of the registers and the controller state
    logic [7:0]  c_close, c_open, c_ramp;
    logic [15:0] c_window, c_hold;
    logic [7:0]  m_target, m_actual;
    logic [1:0]  m_step, m_press;
    logic        m_key_open, m_r_released, m_from_remote;
    logic [31:0] m_last_r, m_s_hold;

    t_result     pending_hatch_out[$];
    logic [31:0] cur_now;
    int          accepted_ticks;
    int          mismatch_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_left;
    int          quiet_cycles;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic predict_hatch_tick(input t_in t, output t_result r);
        logic [31:0] gap;
        logic [8:0]  sum;
        r = '0;
        if (t.starting) begin
            m_target = c_close;
            m_actual = c_close;
            m_r_released = 1'b1;
            m_press = 2'd0;
        end else begin
            if (t.sw2_middle) begin
                if (t.sw1_up) begin
                    if (m_step == STEP_ARMED) m_step = STEP_FIRE;
                    else if (m_step == STEP_FIRE) m_step = STEP_IDLE;
                end else begin
                    m_step = STEP_ARMED;
                end
            end else begin
                m_step = STEP_IDLE;
            end
            if (m_step == STEP_FIRE) m_target = (m_target == c_open) ? c_close : c_open;
            if (t.key_mode) begin
                if (m_from_remote) begin
                    m_key_open = 1'b0;
                    m_target = c_close;
                    m_from_remote = 1'b0;
                end
                if (!m_key_open) begin
                    if (!t.key_r) begin
                        m_r_released = 1'b1;
                        gap = t.now_tick - m_last_r;
                        if (gap > 32'(c_window)) m_press = 2'd0;
                    end
                    if (t.key_r && m_r_released && !t.buff_hit) begin
                        m_last_r = t.now_tick;
                        m_r_released = 1'b0;
                        if (m_press < PRESS_MAX) m_press = m_press + 2'd1;
                    end
                    if (m_press >= PRESS_OPEN) begin
                        m_key_open = 1'b1;
                        m_target = c_open;
                        r.clear_shots = t.shots_nonzero;
                        m_s_hold = t.now_tick;
                    end else begin
                        m_target = c_close;
                    end
                end else begin
                    if (!t.key_r) m_r_released = 1'b1;
                    if (!t.key_s) m_s_hold = t.now_tick;
                    gap = t.now_tick - m_s_hold;
                    if (gap > 32'(c_hold) || t.close_keys) m_key_open = 1'b0;
                    else m_target = c_open;
                    m_press = 2'd0;
                end
            end else begin
                m_key_open = 1'b0;
                m_r_released = 1'b1;
                m_press = 2'd0;
                m_from_remote = 1'b1;
            end
        end
        sum = {1'b0, m_actual} + {1'b0, c_ramp};
        if (m_actual < m_target) begin
            m_actual = (sum > {1'b0, m_target}) ? m_target : sum[7:0];
        end else if (m_actual > m_target) begin
            m_actual = ((m_actual - m_target) > c_ramp) ? m_actual - c_ramp : m_target;
        end
        r.servo_pwm = m_actual;
        r.is_open = (m_actual == c_open);
        r.is_opening = (m_target == c_open);
    endtask

    task automatic drive_tick(input t_in t);
        t_result r;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tdata = {7'd0, t.now_tick, t.shots_nonzero, t.buff_hit, t.close_keys,
                          t.key_s, t.key_r, t.key_mode, t.sw1_up, t.sw2_middle, t.starting};
        i_s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_hatch_tick(t, r);
        pending_hatch_out.push_back(r);
        accepted_ticks++;
        @(negedge i_clk);
    endtask

    function automatic t_in quiet_tick(input logic km, input int unsigned span);
        t_in t;
        t = '0;
        cur_now = cur_now + 32'($urandom_range(0, span));
        t.key_mode = km;
        t.now_tick = cur_now;
        return t;
    endfunction

    task automatic settle_block();
        i_s_axis_tvalid = 1'b0;
        while (pending_hatch_out.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        settle_block();
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = value;
        case (idx)
            REG_CLOSE_PWM:    c_close = value[7:0];
            REG_OPEN_PWM:     c_open = value[7:0];
            REG_RAMP_STEP:    c_ramp = value[7:0];
            REG_PRESS_WINDOW: c_window = value;
            REG_CLOSE_HOLD:   c_hold = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_config(input logic [7:0] cl, input logic [7:0] op, input logic [7:0] rs,
                              input logic [15:0] win, input logic [15:0] hld);
        write_reg(REG_CLOSE_PWM, 16'(cl));
        write_reg(REG_OPEN_PWM, 16'(op));
        write_reg(REG_RAMP_STEP, 16'(rs));
        write_reg(REG_PRESS_WINDOW, win);
        write_reg(REG_CLOSE_HOLD, hld);
    endtask

    task automatic randomize_config();
        logic [7:0] cl, op, rs;
        logic [15:0] win, hld;
        cl = 8'($urandom_range(0, 255));
        op = ($urandom_range(0, 7) == 0) ? cl : 8'($urandom_range(0, 255));
        rs = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(1, 8)) : 8'($urandom_range(1, 255));
        win = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 1000))
                                          : 16'($urandom_range(0, 65535));
        hld = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 1000))
                                          : 16'($urandom_range(0, 65535));
        set_config(cl, op, rs, win, hld);
    endtask

    task automatic check_remote_toggle();
        t_in t;
        t = '1;
        t.now_tick = 32'hFFFF_FFFF;
        drive_tick(t);
        cur_now = 32'd0;
        t = quiet_tick(1'b0, 0);
        drive_tick(t);
        t = quiet_tick(1'b0, 3); t.sw2_middle = 1'b1; drive_tick(t);
        t.sw1_up = 1'b1; drive_tick(t);
        drive_tick(t);
        t.sw1_up = 1'b0; drive_tick(t);
        t.sw1_up = 1'b1; drive_tick(t);
        t = quiet_tick(1'b0, 3); t.sw1_up = 1'b1; drive_tick(t);
    endtask

    task automatic check_key_control();
        t_in t;
        cur_now = 32'hFFFF_FF00;
        t = quiet_tick(1'b1, 0); drive_tick(t);
        // press while aiming does not count
        t = quiet_tick(1'b1, 5); t.key_r = 1'b1; t.buff_hit = 1'b1; drive_tick(t);
        t = quiet_tick(1'b1, 5); drive_tick(t);
        t = quiet_tick(1'b1, 5); t.key_r = 1'b1; drive_tick(t);
        t = quiet_tick(1'b1, 5); drive_tick(t);
        t = quiet_tick(1'b1, 5); t.key_r = 1'b1; t.shots_nonzero = 1'b1; drive_tick(t);
        t = quiet_tick(1'b1, 5); t.key_s = 1'b1; drive_tick(t);
        // long s hold across the tick wrap closes
        cur_now = cur_now + 32'd900;
        t = quiet_tick(1'b1, 0); t.key_s = 1'b1; drive_tick(t);
        t = quiet_tick(1'b1, 5); t.key_r = 1'b1; drive_tick(t);
        t = quiet_tick(1'b1, 5); drive_tick(t);
        t = quiet_tick(1'b1, 5); t.key_r = 1'b1; drive_tick(t);
        t = quiet_tick(1'b1, 5); t.close_keys = 1'b1; drive_tick(t);
        // remote toggle while in key mode, key logic wins
        t = quiet_tick(1'b1, 5); t.sw2_middle = 1'b1; drive_tick(t);
        t.sw1_up = 1'b1; drive_tick(t);
        t = quiet_tick(1'b1, 5); t.starting = 1'b1; drive_tick(t);
        t = quiet_tick(1'b0, 5); drive_tick(t);
    endtask

    task automatic check_special_settings();
        t_in t;
        write_reg(REG_RAMP_STEP, 16'd0);
        t = quiet_tick(1'b0, 3); t.sw2_middle = 1'b1; drive_tick(t);
        t.sw1_up = 1'b1; drive_tick(t);
        write_reg(REG_RAMP_STEP, 16'(RST_RAMP_STEP));
        write_reg(REG_OPEN_PWM, 16'(RST_CLOSE_PWM));
        t = quiet_tick(1'b0, 3); t.sw2_middle = 1'b1; drive_tick(t);
        t.sw1_up = 1'b1; drive_tick(t);
        write_reg(REG_OPEN_PWM, 16'(RST_OPEN_PWM));
    endtask

    task automatic random_episode();
        t_in t;
        int kind;
        int unsigned span;
        logic km;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            km = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3)) begin
                t = quiet_tick(km, 8); t.sw2_middle = 1'b1; drive_tick(t);
            end
            repeat ($urandom_range(1, 3)) begin
                t = quiet_tick(km, 8);
                t.sw2_middle = ($urandom_range(0, 7) != 0);
                t.sw1_up = 1'b1;
                drive_tick(t);
            end
        end else if (kind < 60) begin
            span = ($urandom_range(0, 3) != 0) ? 32'(c_window / 2) : 2 * c_window + 4;
            repeat ($urandom_range(2, 4)) begin
                t = quiet_tick(1'b1, span);
                t.key_r = 1'b1;
                t.buff_hit = ($urandom_range(0, 9) == 0);
                t.shots_nonzero = 1'($urandom_range(0, 1));
                drive_tick(t);
                t = quiet_tick(1'b1, span);
                t.key_r = ($urandom_range(0, 5) == 0);
                drive_tick(t);
            end
            repeat ($urandom_range(2, 8)) begin
                t = quiet_tick(1'b1, c_hold / 3 + 2);
                t.key_s = ($urandom_range(0, 3) != 0);
                t.close_keys = ($urandom_range(0, 11) == 0);
                t.key_r = ($urandom_range(0, 5) == 0);
                t.shots_nonzero = 1'($urandom_range(0, 1));
                drive_tick(t);
            end
        end else if (kind < 75) begin
            repeat ($urandom_range(1, 4)) begin
                t = quiet_tick(1'($urandom_range(0, 1)), 16);
                drive_tick(t);
            end
        end else begin
            t = quiet_tick(1'b0, 64);
            {t.starting, t.sw2_middle, t.sw1_up, t.key_mode, t.key_r, t.key_s,
             t.close_keys, t.buff_hit, t.shots_nonzero} = 9'($urandom);
            if (kind >= 80) t.starting = ($urandom_range(0, 7) == 0);
            else t.starting = 1'b1;
            if ($urandom_range(0, 1) != 0) begin
                t.now_tick = $urandom;
                cur_now = t.now_tick;
            end
            drive_tick(t);
        end
    endtask

    task automatic run_random_ticks(input int n, input int idle_pct, input int stall_pct);
        int first;
        first = accepted_ticks;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        while (accepted_ticks - first < n) random_episode();
    endtask

    task automatic check_output_stall();
        hold_left = 50;
        run_random_ticks(80, 0, 0);
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_m_axis_tready = 1'b0;
            hold_left--;
        end else begin
            i_m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_hatch_out.size() == 0) begin
                $error("result word with nothing expected: %h", o_m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_hatch_out.pop_front();
                if (o_m_axis_tdata[7:0] !== want.servo_pwm) begin
                    $error("servo_pwm: expected %0d, got %0d", want.servo_pwm,
                           o_m_axis_tdata[7:0]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[8] !== want.is_open) begin
                    $error("is_open: expected %0d, got %0d", want.is_open, o_m_axis_tdata[8]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[9] !== want.is_opening) begin
                    $error("is_opening: expected %0d, got %0d", want.is_opening,
                           o_m_axis_tdata[9]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[10] !== want.clear_shots) begin
                    $error("clear_shots: expected %0d, got %0d", want.clear_shots,
                           o_m_axis_tdata[10]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        accepted_ticks = 0;
        mismatch_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        quiet_cycles = 0;
        cur_now = 32'd0;
        c_close = RST_CLOSE_PWM;
        c_open = RST_OPEN_PWM;
        c_ramp = RST_RAMP_STEP;
        c_window = RST_PRESS_WINDOW;
        c_hold = RST_CLOSE_HOLD;
        m_target = RST_CLOSE_PWM;
        m_actual = RST_CLOSE_PWM;
        m_step = STEP_IDLE;
        m_press = 2'd0;
        m_key_open = 1'b0;
        m_r_released = 1'b1;
        m_from_remote = 1'b1;
        m_last_r = 32'd0;
        m_s_hold = 32'd0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        check_remote_toggle();
        check_key_control();
        check_special_settings();
        check_output_stall();

        set_config(8'd0, 8'd255, 8'd1, 16'd0, 16'd0);
        run_random_ticks(220, 0, 0);
        set_config(8'd255, 8'd0, 8'd255, 16'hFFFF, 16'hFFFF);
        run_random_ticks(220, 70, 0);
        randomize_config();
        run_random_ticks(220, 0, 70);
        randomize_config();
        run_random_ticks(220, 22, 22);
        set_config(RST_CLOSE_PWM, RST_OPEN_PWM, RST_RAMP_STEP, RST_PRESS_WINDOW,
                   RST_CLOSE_HOLD);
        run_random_ticks(220, 0, 0);
        randomize_config();
        run_random_ticks(220, 70, 0);
        randomize_config();
        run_random_ticks(220, 0, 70);
        randomize_config();
        run_random_ticks(220, 22, 22);

        settle_block();
        if (mismatch_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
